>>> rtl/midpoint_circle_rasterizer_top_assert.svh
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top_assert
// Assertion macros shared by the rasterizer RTL.
// ----------------------------------------------------------------------------
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define MCR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MCR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared constants and types for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;

    // Most pixels one item can produce (eight-way symmetry).
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_type_t;

endpackage

>>> rtl/mcr_req_if.sv
// ----------------------------------------------------------------------------
// mcr_req_if
// Request channel: start a circle or advance one octant step.
// ----------------------------------------------------------------------------
interface mcr_req_if #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;

    modport source (output valid, output req_type, output center_x,
                    output center_y, output radius, input ready);
    modport sink   (input valid, input req_type, input center_x,
                    input center_y, input radius, output ready);
endinterface

>>> rtl/mcr_pix_if.sv
// ----------------------------------------------------------------------------
// mcr_pix_if
// Pixel channel: one result per transaction.
// ----------------------------------------------------------------------------
interface mcr_pix_if #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [COORD_BITS+1:0] pixel_x;
    logic signed [COORD_BITS+1:0] pixel_y;
    logic                        pixel_valid;
    logic                        last;
    logic                        done_res;

    modport source (output valid, output pixel_x, output pixel_y,
                    output pixel_valid, output last, output done_res, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input pixel_valid, input last, input done_res, output ready);
endinterface

>>> rtl/midpoint_circle_rasterizer_top.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top
// Midpoint circle rasterizer: start/step requests in, mirrored pixels out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                       | handshake
//  --------+-----+-----------------------------------------------+-----------
//  req     | in  | req_type, center_x, center_y, radius          | valid/ready
//  pix     | out | pixel_x, pixel_y, pixel_valid, last, done_res | valid/ready
//
//  Request register -> octant update and pixel generation -> 8-slot result
//  register, shifted out one pixel per cycle while pix.ready is high. A
//  request passes the request register, then the result slots, before its
//  first result. Results per item: 1 or 4 for a start, 1, 4 or 8 for a step.
//  A request is taken while the previous item's results are still draining.
//  Reset clears the octant state, the centre and both stage valids.
// ----------------------------------------------------------------------------
`include "midpoint_circle_rasterizer_top_assert.svh"

module midpoint_circle_rasterizer_top #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mcr_req_if.sink       req,
    mcr_pix_if.source     pix
);

    localparam int OB = COORD_BITS + 2;   // pixel coordinate width
    localparam int RB = RADIUS_BITS;
    localparam int DB = RADIUS_BITS + 3;  // decision term width
    localparam int NS = mcr_pkg::NUM_SLOTS;
    localparam int SB = mcr_pkg::SLOT_BITS;

    // request stage
    logic                   a_vld_reg;
    mcr_pkg::req_type_t     a_req_reg;
    logic [COORD_BITS-1:0]  a_cx_reg;
    logic [COORD_BITS-1:0]  a_cy_reg;
    logic [RB-1:0]          a_r_reg;

    // octant state
    logic [RB-1:0]          ox_reg, ox_next;
    logic [RB-1:0]          oy_reg, oy_next;
    logic [DB-1:0]          dec_reg, dec_next;
    logic [COORD_BITS-1:0]  hcx_reg, hcx_next;
    logic [COORD_BITS-1:0]  hcy_reg, hcy_next;
    logic                   active_reg, active_next;

    // result slots
    logic                   b_vld_reg;
    logic [SB-1:0]          b_cnt_reg, b_cnt_next;
    logic                   b_pval_reg, b_pval_next;
    logic                   b_done_reg, b_done_next;
    logic [OB-1:0]          px_reg [NS];
    logic [OB-1:0]          py_reg [NS];
    logic [OB-1:0]          px_next [NS];
    logic [OB-1:0]          py_next [NS];

    // handshake
    logic pix_take;
    logic b_free;
    logic a_move;

    // step arithmetic
    logic          dec_le0;
    logic [RB-1:0] nx_step, ny_step;
    logic [DB-1:0] nyd, nxd, dec_step;
    logic [OB-1:0] cx_o, cy_o, r_o, hx_o, hy_o, x_o, y_o;

    assign pix_take  = b_vld_reg && pix.ready;
    assign b_free    = !b_vld_reg || (pix_take && (b_cnt_reg == '0));
    assign a_move    = a_vld_reg && b_free;
    assign req.ready = !a_vld_reg || a_move;

    assign pix.valid       = b_vld_reg;
    assign pix.pixel_x     = px_reg[0];
    assign pix.pixel_y     = py_reg[0];
    assign pix.pixel_valid = b_pval_reg;
    assign pix.last        = (b_cnt_reg == '0);
    assign pix.done_res    = b_done_reg;

    assign dec_le0  = dec_reg[DB-1] || (dec_reg == '0);
    assign ny_step  = oy_reg + RB'(1);
    assign nx_step  = dec_le0 ? ox_reg : ox_reg - RB'(1);
    assign nyd      = DB'(ny_step);
    assign nxd      = DB'(nx_step);
    assign dec_step = dec_reg + (nyd << 1) + DB'(1) - (dec_le0 ? '0 : (nxd << 1));

    assign cx_o = OB'(a_cx_reg);
    assign cy_o = OB'(a_cy_reg);
    assign r_o  = OB'(a_r_reg);
    assign hx_o = OB'(hcx_reg);
    assign hy_o = OB'(hcy_reg);
    assign x_o  = OB'(nx_step);
    assign y_o  = OB'(ny_step);

    always_comb
    begin
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        dec_next    = dec_reg;
        hcx_next    = hcx_reg;
        hcy_next    = hcy_reg;
        active_next = active_reg;
        b_cnt_next  = '0;
        b_pval_next = 1'b0;
        b_done_next = 1'b1;
        for (int i = 0; i < NS; i++)
        begin
            px_next[i] = '0;
            py_next[i] = '0;
        end

        unique case (a_req_reg)
            mcr_pkg::REQ_START:
            begin
                hcx_next    = a_cx_reg;
                hcy_next    = a_cy_reg;
                ox_next     = a_r_reg;
                oy_next     = '0;
                dec_next    = DB'(1) - DB'(a_r_reg);
                active_next = (a_r_reg != '0);
                b_pval_next = 1'b1;
                b_done_next = (a_r_reg == '0);
                if (a_r_reg == '0)
                begin
                    px_next[0] = cx_o;
                    py_next[0] = cy_o;
                end
                else
                begin
                    b_cnt_next = SB'(3);
                    px_next[0] = cx_o + r_o;  py_next[0] = cy_o;
                    px_next[1] = cx_o - r_o;  py_next[1] = cy_o;
                    px_next[2] = cx_o;        py_next[2] = cy_o + r_o;
                    px_next[3] = cx_o;        py_next[3] = cy_o - r_o;
                end
            end
            mcr_pkg::REQ_STEP:
            begin
                if (active_reg)
                begin
                    ox_next  = nx_step;
                    oy_next  = ny_step;
                    dec_next = dec_step;
                    if (nx_step < ny_step)
                    begin
                        // overshoot: single empty result
                        active_next = 1'b0;
                    end
                    else
                    begin
                        active_next = (nx_step > ny_step);
                        b_pval_next = 1'b1;
                        b_done_next = !(nx_step > ny_step);
                        b_cnt_next  = (nx_step != ny_step) ? SB'(7) : SB'(3);
                        px_next[0] = hx_o + x_o;  py_next[0] = hy_o + y_o;
                        px_next[1] = hx_o - x_o;  py_next[1] = hy_o + y_o;
                        px_next[2] = hx_o + x_o;  py_next[2] = hy_o - y_o;
                        px_next[3] = hx_o - x_o;  py_next[3] = hy_o - y_o;
                        px_next[4] = hx_o + y_o;  py_next[4] = hy_o + x_o;
                        px_next[5] = hx_o - y_o;  py_next[5] = hy_o + x_o;
                        px_next[6] = hx_o + y_o;  py_next[6] = hy_o - x_o;
                        px_next[7] = hx_o - y_o;  py_next[7] = hy_o - x_o;
                    end
                end
            end
            default:
            begin
                b_cnt_next = '0;
            end
        endcase
    end

    // request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            a_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            a_req_reg <= mcr_pkg::req_type_t'(req.req_type);
            a_cx_reg  <= req.center_x;
            a_cy_reg  <= req.center_y;
            a_r_reg   <= req.radius;
        end
    end

    // octant state, updated as an item moves into the result slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg     <= '0;
            oy_reg     <= '0;
            dec_reg    <= '0;
            hcx_reg    <= '0;
            hcy_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (a_move)
        begin
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            dec_reg    <= dec_next;
            hcx_reg    <= hcx_next;
            hcy_reg    <= hcy_next;
            active_reg <= active_next;
        end
    end

    // result slot control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            b_cnt_reg <= '0;
        end
        else if (a_move)
        begin
            b_vld_reg <= 1'b1;
            b_cnt_reg <= b_cnt_next;
        end
        else if (pix_take)
        begin
            if (b_cnt_reg == '0)
            begin
                b_vld_reg <= 1'b0;
            end
            else
            begin
                b_cnt_reg <= b_cnt_reg - SB'(1);
            end
        end
    end

    // result slot payload: load, then shift toward slot 0 per transaction
    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_pval_reg <= b_pval_next;
            b_done_reg <= b_done_next;
            for (int i = 0; i < NS; i++)
            begin
                px_reg[i] <= px_next[i];
                py_reg[i] <= py_next[i];
            end
        end
        else if (pix_take)
        begin
            for (int i = 0; i < NS - 1; i++)
            begin
                px_reg[i] <= px_reg[i+1];
                py_reg[i] <= py_reg[i+1];
            end
        end
    end

    `MCR_ASSERT_NOW(a_active_order, active_reg, ox_reg > oy_reg, "active with x not above y")
    `MCR_ASSERT_NOW(a_empty_is_last, b_vld_reg && !b_pval_reg, b_cnt_reg == '0, "empty result not last")
    `MCR_ASSERT_NOW(a_open_has_pixel, b_vld_reg && !b_done_reg, b_pval_reg, "open circle without pixel")
    `MCR_ASSERT_NEXT(a_burst_continues, pix_take && (b_cnt_reg != '0), b_vld_reg, "burst cut short")
    `MCR_ASSERT_NEXT(a_req_held, a_vld_reg && !a_move, a_vld_reg, "request stage dropped")

endmodule
